// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define CPCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cpcr assertion failed");
// Check that a condition never holds outside reset.
`define CPCR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cpcr forbidden condition seen");
`else
`define CPCR_ASSERT(lbl, clk, rst_n, prop)
`define CPCR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/cpcr_pkg.sv
// Types, constants and helpers of the circle pair collision resolver.
package cpcr_pkg;

    typedef struct packed {
        logic [31:0] a_x;
        logic [31:0] a_y;
        logic [31:0] b_x;
        logic [31:0] b_y;
        logic [23:0] a_radius;
        logic [23:0] b_radius;
        logic [2:0]  a_mass_class;
        logic [2:0]  b_mass_class;
    } in_word_t;

    typedef struct packed {
        logic        collided;
        logic [31:0] new_a_x;
        logic [31:0] new_a_y;
        logic [31:0] new_b_x;
        logic [31:0] new_b_y;
    } out_word_t;

    localparam int CFG_W = 24;

    // register indexes
    localparam logic [2:0] REG_WALL    = 3'd0;
    localparam logic [2:0] REG_TITAN   = 3'd1;
    localparam logic [2:0] REG_HUMAN   = 3'd2;
    localparam logic [2:0] REG_SWARM   = 3'd3;
    localparam logic [2:0] REG_DEFAULT = 3'd4;

    // mass class codes
    localparam logic [2:0] CLASS_WALL  = 3'd0;
    localparam logic [2:0] CLASS_TITAN = 3'd1;
    localparam logic [2:0] CLASS_HUMAN = 3'd2;
    localparam logic [2:0] CLASS_SWARM = 3'd3;

    localparam logic [CFG_W-1:0] WALL_RST    = 24'd1000000;
    localparam logic [CFG_W-1:0] TITAN_RST   = 24'd40000;
    localparam logic [CFG_W-1:0] HUMAN_RST   = 24'd100;
    localparam logic [CFG_W-1:0] SWARM_RST   = 24'd15;
    localparam logic [CFG_W-1:0] DEFAULT_RST = 24'd1;

    localparam int SQRT_W  = 26;   // root bits of the squared distance
    localparam int NDIV_QW = 31;   // normal component bits
    localparam int PDIV_QW = 25;   // mass share bits
    localparam int MAG_W   = 25;   // offset magnitude bits below the far limit

    localparam logic [PDIV_QW-1:0] HALF_SHARE = 25'd8388608;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'h7fff_ffff;
        end
        else if (v < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/circle_pair_collision_resolve.sv
// Top level: config registers, offset and squares, root and divide pipes, push and skid.
//
//  channel | handshake                  | word
//  --------+----------------------------+---------------------------
//  in      | in_valid / in_ready        | in_data  (in_word_t)
//  out     | out_valid / out_ready      | out_data (out_word_t)
//  config  | psel/penable/pwrite, pready| paddr, pwdata, prdata
//
// One pair enters per cycle while the output buffer is not full; each result passes through
// the 26-stage square root and the 31-stage normal divider plus seven arithmetic stages.
// Reset clears the valid bits, the output buffer and sets the weights to defaults.
// A two-word output buffer absorbs stalls; the pipe holds only once both words are full.
`include "assert_macros.svh"
module circle_pair_collision_resolve
    import cpcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data
);

    localparam int LAT = 4 + SQRT_W + NDIV_QW + 3;
    localparam logic [63:0] NEAR_LIMIT =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] w_wall_reg, w_titan_reg, w_human_reg, w_swarm_reg, w_default_reg;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_wall_reg    <= WALL_RST;
            w_titan_reg   <= TITAN_RST;
            w_human_reg   <= HUMAN_RST;
            w_swarm_reg   <= SWARM_RST;
            w_default_reg <= DEFAULT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WALL:    w_wall_reg    <= pwdata[CFG_W-1:0];
                REG_TITAN:   w_titan_reg   <= pwdata[CFG_W-1:0];
                REG_HUMAN:   w_human_reg   <= pwdata[CFG_W-1:0];
                REG_SWARM:   w_swarm_reg   <= pwdata[CFG_W-1:0];
                REG_DEFAULT: w_default_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WALL:    cfg_rd = w_wall_reg;
            REG_TITAN:   cfg_rd = w_titan_reg;
            REG_HUMAN:   cfg_rd = w_human_reg;
            REG_SWARM:   cfg_rd = w_swarm_reg;
            REG_DEFAULT: cfg_rd = w_default_reg;
            default:     cfg_rd = '0;
        endcase
    end

    assign prdata = {{(32-CFG_W){1'b0}}, cfg_rd};

    // ---------------- flow control ----------------
    logic [1:0]     cnt_reg;
    logic [LAT-1:0] valid_reg;
    logic           en;
    logic           accept;
    logic           push;
    logic           pop;

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
        end
    end

    // ---------------- stage A: capture ----------------
    in_word_t a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= in_data;
        end
    end

    // ---------------- stage B: offsets, radius sum, weights ----------------
    function automatic logic [CFG_W-1:0] pick_weight(input logic [2:0] code,
        input logic [CFG_W-1:0] w0, input logic [CFG_W-1:0] w1,
        input logic [CFG_W-1:0] w2, input logic [CFG_W-1:0] w3,
        input logic [CFG_W-1:0] w4);
        logic [CFG_W-1:0] w;
        unique case (code)
            CLASS_WALL:  w = w0;
            CLASS_TITAN: w = w1;
            CLASS_HUMAN: w = w2;
            CLASS_SWARM: w = w3;
            default:     w = w4;
        endcase
        return w;
    endfunction

    logic [32:0]      dx_next, dy_next, mx_next, my_next;
    logic [CFG_W-1:0] wa_next, wb_next;

    assign dx_next = {a_reg.b_x[31], a_reg.b_x} - {a_reg.a_x[31], a_reg.a_x};
    assign dy_next = {a_reg.b_y[31], a_reg.b_y} - {a_reg.a_y[31], a_reg.a_y};
    assign mx_next = dx_next[32] ? (~dx_next + 33'd1) : dx_next;
    assign my_next = dy_next[32] ? (~dy_next + 33'd1) : dy_next;
    assign wa_next = pick_weight(a_reg.a_mass_class, w_wall_reg, w_titan_reg,
                                 w_human_reg, w_swarm_reg, w_default_reg);
    assign wb_next = pick_weight(a_reg.b_mass_class, w_wall_reg, w_titan_reg,
                                 w_human_reg, w_swarm_reg, w_default_reg);

    logic [127:0]     bc_reg;   // ax, ay, bx, by
    logic             b_sx_reg, b_sy_reg, b_far_reg;
    logic [MAG_W-1:0] b_mx_reg, b_my_reg, b_minr_reg;
    logic [CFG_W:0]   b_tot_reg;
    logic [CFG_W-1:0] b_wb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bc_reg     <= {a_reg.a_x, a_reg.a_y, a_reg.b_x, a_reg.b_y};
            b_sx_reg   <= dx_next[32];
            b_sy_reg   <= dy_next[32];
            b_far_reg  <= (|mx_next[32:MAG_W]) || (|my_next[32:MAG_W]);
            b_mx_reg   <= mx_next[MAG_W-1:0];
            b_my_reg   <= my_next[MAG_W-1:0];
            b_minr_reg <= {1'b0, a_reg.a_radius} + {1'b0, a_reg.b_radius};
            b_tot_reg  <= {1'b0, wa_next} + {1'b0, wb_next};
            b_wb_reg   <= wb_next;
        end
    end

    // ---------------- stage C: squares ----------------
    logic [127:0]       cc_reg;
    logic               c_sx_reg, c_sy_reg, c_far_reg;
    logic [MAG_W-1:0]   c_mx_reg, c_my_reg, c_minr_reg;
    logic [2*MAG_W-1:0] c_sqx_reg, c_sqy_reg, c_msq_reg;
    logic [CFG_W:0]     c_tot_reg;
    logic [CFG_W-1:0]   c_wb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg     <= bc_reg;
            c_sx_reg   <= b_sx_reg;
            c_sy_reg   <= b_sy_reg;
            c_far_reg  <= b_far_reg;
            c_mx_reg   <= b_mx_reg;
            c_my_reg   <= b_my_reg;
            c_minr_reg <= b_minr_reg;
            c_sqx_reg  <= b_mx_reg * b_mx_reg;
            c_sqy_reg  <= b_my_reg * b_my_reg;
            c_msq_reg  <= b_minr_reg * b_minr_reg;
            c_tot_reg  <= b_tot_reg;
            c_wb_reg   <= b_wb_reg;
        end
    end

    // ---------------- stage D: distance test ----------------
    logic [2*MAG_W:0] dsq_next;
    assign dsq_next = {1'b0, c_sqx_reg} + {1'b0, c_sqy_reg};

    logic [127:0]       dc_reg;
    logic               d_sx_reg, d_sy_reg, d_hit_reg, d_tz_reg;
    logic [MAG_W-1:0]   d_mx_reg, d_my_reg, d_minr_reg;
    logic [2*MAG_W:0]   d_dsq_reg;
    logic [CFG_W:0]     d_tot_reg;
    logic [CFG_W-1:0]   d_wb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_reg     <= cc_reg;
            d_sx_reg   <= c_sx_reg;
            d_sy_reg   <= c_sy_reg;
            d_hit_reg  <= !c_far_reg && (dsq_next < {1'b0, c_msq_reg}) &&
                          ({{(63-2*MAG_W){1'b0}}, dsq_next} >= NEAR_LIMIT);
            d_tz_reg   <= (c_tot_reg == '0);
            d_mx_reg   <= c_mx_reg;
            d_my_reg   <= c_my_reg;
            d_minr_reg <= c_minr_reg;
            d_dsq_reg  <= dsq_next;
            d_tot_reg  <= c_tot_reg;
            d_wb_reg   <= c_wb_reg;
        end
    end

    // ---------------- root, shares ----------------
    logic [SQRT_W-1:0] dlen;
    logic [PDIV_QW-1:0] pa_q, pb_q, pa_d, pb_d;
    logic [CFG_W:0]    wa_num;

    assign wa_num = d_tot_reg - {1'b0, d_wb_reg};

    cpcr_isqrt #(.RW(SQRT_W)) u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  ({{(2*SQRT_W-2*MAG_W-1){1'b0}}, d_dsq_reg}),
        .root (dlen)
    );

    cpcr_div #(.DW(CFG_W+1), .QW(PDIV_QW)) u_div_pa (
        .clk (clk),
        .en  (en),
        .num ({1'b0, d_wb_reg}),
        .den (d_tot_reg),
        .q   (pa_q)
    );

    cpcr_div #(.DW(CFG_W+1), .QW(PDIV_QW)) u_div_pb (
        .clk (clk),
        .en  (en),
        .num (wa_num),
        .den (d_tot_reg),
        .q   (pb_q)
    );

    cpcr_delay #(.W(2*PDIV_QW), .N(SQRT_W - PDIV_QW)) u_dly_p (
        .clk  (clk),
        .en   (en),
        .din  ({pa_q, pb_q}),
        .dout ({pa_d, pb_d})
    );

    localparam int S1_W = 128 + 2 + 2 + 3*MAG_W;
    logic [127:0]     s1_c;
    logic             s1_sx, s1_sy, s1_hit, s1_tz;
    logic [MAG_W-1:0] s1_mx, s1_my, s1_minr;

    cpcr_delay #(.W(S1_W), .N(SQRT_W)) u_dly_s1 (
        .clk  (clk),
        .en   (en),
        .din  ({dc_reg, d_sx_reg, d_sy_reg, d_hit_reg, d_tz_reg,
                d_mx_reg, d_my_reg, d_minr_reg}),
        .dout ({s1_c, s1_sx, s1_sy, s1_hit, s1_tz, s1_mx, s1_my, s1_minr})
    );

    // ---------------- normal components ----------------
    logic [SQRT_W-1:0]  ovl_full;
    logic [PDIV_QW-1:0] pa_sel, pb_sel;
    logic [NDIV_QW-1:0] nx_q, ny_q;

    assign ovl_full = {1'b0, s1_minr} - dlen;
    // both weights zero: split the overlap evenly
    assign pa_sel = s1_tz ? HALF_SHARE : pa_d;
    assign pb_sel = s1_tz ? HALF_SHARE : pb_d;

    cpcr_div #(.DW(SQRT_W), .QW(NDIV_QW)) u_div_nx (
        .clk (clk),
        .en  (en),
        .num ({1'b0, s1_mx}),
        .den (dlen),
        .q   (nx_q)
    );

    cpcr_div #(.DW(SQRT_W), .QW(NDIV_QW)) u_div_ny (
        .clk (clk),
        .en  (en),
        .num ({1'b0, s1_my}),
        .den (dlen),
        .q   (ny_q)
    );

    localparam int S2_W = 128 + 3 + MAG_W + 2*PDIV_QW;
    logic [127:0]       s2_c;
    logic               s2_sx, s2_sy, s2_hit;
    logic [MAG_W-1:0]   s2_ovl;
    logic [PDIV_QW-1:0] s2_pa, s2_pb;

    cpcr_delay #(.W(S2_W), .N(NDIV_QW)) u_dly_s2 (
        .clk  (clk),
        .en   (en),
        .din  ({s1_c, s1_sx, s1_sy, s1_hit, ovl_full[MAG_W-1:0], pa_sel, pb_sel}),
        .dout ({s2_c, s2_sx, s2_sy, s2_hit, s2_ovl, s2_pa, s2_pb})
    );

    // ---------------- stage F: scale by overlap ----------------
    logic [NDIV_QW+MAG_W-1:0] tx_prod, ty_prod;
    assign tx_prod = nx_q * s2_ovl;
    assign ty_prod = ny_q * s2_ovl;

    logic [127:0]       fc_reg;
    logic               f_sx_reg, f_sy_reg, f_hit_reg;
    logic [PDIV_QW-1:0] f_pa_reg, f_pb_reg;
    logic [38:0]        f_tx_reg, f_ty_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fc_reg    <= s2_c;
            f_sx_reg  <= s2_sx;
            f_sy_reg  <= s2_sy;
            f_hit_reg <= s2_hit;
            f_pa_reg  <= s2_pa;
            f_pb_reg  <= s2_pb;
            f_tx_reg  <= tx_prod[54:16];
            f_ty_reg  <= ty_prod[54:16];
        end
    end

    // ---------------- stage G: scale by mass share ----------------
    logic [63:0] max_prod, may_prod, mbx_prod, mby_prod;
    assign max_prod = f_tx_reg * f_pa_reg;
    assign may_prod = f_ty_reg * f_pa_reg;
    assign mbx_prod = f_tx_reg * f_pb_reg;
    assign mby_prod = f_ty_reg * f_pb_reg;

    logic [127:0]     gc_reg;
    logic             g_sx_reg, g_sy_reg, g_hit_reg;
    logic [MAG_W-1:0] g_max_reg, g_may_reg, g_mbx_reg, g_mby_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gc_reg    <= fc_reg;
            g_sx_reg  <= f_sx_reg;
            g_sy_reg  <= f_sy_reg;
            g_hit_reg <= f_hit_reg;
            g_max_reg <= max_prod[62:38];
            g_may_reg <= may_prod[62:38];
            g_mbx_reg <= mbx_prod[62:38];
            g_mby_reg <= mby_prod[62:38];
        end
    end

    // ---------------- stage H: move and saturate ----------------
    logic signed [33:0] ax_e, ay_e, bx_e, by_e;
    logic signed [33:0] max_e, may_e, mbx_e, mby_e;
    logic signed [33:0] nax, nay, nbx, nby;
    out_word_t          h_next;
    out_word_t          h_reg;

    assign ax_e  = $signed({{2{gc_reg[127]}}, gc_reg[127:96]});
    assign ay_e  = $signed({{2{gc_reg[95]}},  gc_reg[95:64]});
    assign bx_e  = $signed({{2{gc_reg[63]}},  gc_reg[63:32]});
    assign by_e  = $signed({{2{gc_reg[31]}},  gc_reg[31:0]});
    assign max_e = $signed({{(34-MAG_W){1'b0}}, g_max_reg});
    assign may_e = $signed({{(34-MAG_W){1'b0}}, g_may_reg});
    assign mbx_e = $signed({{(34-MAG_W){1'b0}}, g_mbx_reg});
    assign mby_e = $signed({{(34-MAG_W){1'b0}}, g_mby_reg});

    // push A against the offset and B along it
    assign nax = g_sx_reg ? (ax_e + max_e) : (ax_e - max_e);
    assign nay = g_sy_reg ? (ay_e + may_e) : (ay_e - may_e);
    assign nbx = g_sx_reg ? (bx_e - mbx_e) : (bx_e + mbx_e);
    assign nby = g_sy_reg ? (by_e - mby_e) : (by_e + mby_e);

    always_comb
    begin
        h_next.collided = g_hit_reg;
        if (g_hit_reg)
        begin
            h_next.new_a_x = sat32(nax);
            h_next.new_a_y = sat32(nay);
            h_next.new_b_x = sat32(nbx);
            h_next.new_b_y = sat32(nby);
        end
        else
        begin
            h_next.new_a_x = gc_reg[127:96];
            h_next.new_a_y = gc_reg[95:64];
            h_next.new_b_x = gc_reg[63:32];
            h_next.new_b_y = gc_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= h_next;
        end
    end

    // ---------------- output buffer ----------------
    out_word_t sk0_reg, sk1_reg;

    assign push      = en && valid_reg[LAT-1];
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = sk0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cnt_reg == 2'd2 && pop)
        begin
            sk0_reg <= sk1_reg;
        end
        else if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        begin
            sk0_reg <= h_reg;
        end
        else if (push && cnt_reg == 2'd1)
        begin
            sk1_reg <= h_reg;
        end
    end

    `CPCR_NEVER(a_cnt_range, clk, rst_n, cnt_reg == 2'd3)
    `CPCR_ASSERT(a_full_stalls, clk, rst_n, (cnt_reg == 2'd2) |-> !in_ready)
    `CPCR_ASSERT(a_drain_step, clk, rst_n, (cnt_reg == 2'd2 && pop) |=> (cnt_reg == 2'd1))

endmodule

// File: rtl/cpcr_delay.sv
// Delay line that carries side data alongside the arithmetic pipes.
module cpcr_delay
    import cpcr_pkg::*;
#(
    parameter int W = 8,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
        end
    end

    for (genvar i = 1; i < N; i++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

// File: rtl/cpcr_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module cpcr_isqrt
    import cpcr_pkg::*;
#(
    parameter int RW = 26
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [RW+3:0]   sh;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign sh    = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = sh - trial;
        assign ge    = (sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[RW+1:0] : sh[RW+1:0];
                root_reg[i] <= {root_in[RW-2:0], ge};
                rad_reg[i]  <= {rad_in[2*RW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: rtl/cpcr_div.sv
// Pipelined restoring divider: q = (num << (QW-1)) / den for num <= den.
module cpcr_div
    import cpcr_pkg::*;
#(
    parameter int DW = 26,
    parameter int QW = 31
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] q
);

    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] bits_reg [QW];
    logic [QW-1:0] q_reg    [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] bits_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            // the top part of the dividend is num >> 1, which stays below den
            assign rem_in  = {1'b0, num[DW-1:1]};
            assign den_in  = den;
            assign bits_in = {num[0], {(QW-1){1'b0}}};
            assign q_in    = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign bits_in = bits_reg[i-1];
            assign q_in    = q_reg[i-1];
        end

        assign sh   = {rem_in, bits_in[QW-1]};
        assign diff = sh - {1'b0, den_in};
        assign ge   = (sh >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
                den_reg[i]  <= den_in;
                bits_reg[i] <= {bits_in[QW-2:0], 1'b0};
                q_reg[i]    <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign q = q_reg[QW-1];

endmodule
